// ----- src/dtv_pkg.sv -----
// ----------------------------------------------------------------------------
// dtv_pkg
// Shared types and constants of the delimited table stream validator.
// ----------------------------------------------------------------------------
package dtv_pkg;

    localparam int LenW      = 24;
    localparam int ColW      = 11;
    localparam int BlockBits = 4;
    localparam logic [LenW-1:0] BlockBytes = 24'd16;
    localparam logic [LenW-1:0] LenMax   = {LenW{1'b1}};
    localparam logic [ColW-1:0] ColBound = 11'd1024;
    localparam logic [ColW-1:0] TallyMax = 11'd1025;

    localparam logic [7:0] ChCr  = 8'd13;
    localparam logic [7:0] ChLf  = 8'd10;
    localparam logic [7:0] ChNul = 8'd0;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SEP       = 4'd1;
    localparam logic [3:0] ST_EMPTY     = 4'd2;
    localparam logic [3:0] ST_SIZE      = 4'd3;
    localparam logic [3:0] ST_LIMIT     = 4'd4;
    localparam logic [3:0] ST_PADLEN    = 4'd5;
    localparam logic [3:0] ST_PADNZ     = 4'd6;
    localparam logic [3:0] ST_NUL       = 4'd7;
    localparam logic [3:0] ST_LINEEND   = 4'd8;
    localparam logic [3:0] ST_NOHDR     = 4'd9;
    localparam logic [3:0] ST_COLS      = 4'd10;
    localparam logic [3:0] ST_EMPTYNAME = 4'd11;
    localparam logic [3:0] ST_ROWS      = 4'd12;
    localparam logic [3:0] ST_MISMATCH  = 4'd13;

    localparam logic [1:0] REG_SEP     = 2'd0;
    localparam logic [1:0] REG_MAXPAY  = 2'd1;
    localparam logic [1:0] REG_MAXCOL  = 2'd2;
    localparam logic [1:0] REG_MAXROWS = 2'd3;

    typedef struct packed {
        logic [7:0]      data;
        logic [LenW-1:0] pos;
        logic [LenW-1:0] len;
        logic            first;
        logic            pos0;
        logic            padbad;
        logic            payload;
        logic            lastpay;
        logic            final_b;
    } t_entry;

    typedef struct packed {
        logic [3:0]      status;
        logic [LenW-1:0] error_offset;
        logic [LenW-1:0] row_idx;
        logic [ColW-1:0] column_count;
        logic [LenW-1:0] row_count;
        logic [3:0]      pad_bytes;
    } t_result;

    typedef struct packed {
        logic [7:0]      separator;
        logic [LenW-1:0] max_payload;
        logic [ColW-1:0] max_columns;
        logic [LenW-1:0] max_rows;
    } t_cfg;

endpackage

// ----- src/dtv_front.sv -----
// ----------------------------------------------------------------------------
// dtv_front
// Tracks stream position, classifies each byte and queues it for the back end.
// ----------------------------------------------------------------------------
module dtv_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_is_first,
    input  logic [dtv_pkg::LenW-1:0] i_total_bytes,
    output logic                  o_valid,
    output dtv_pkg::t_entry       o_entry,
    input  logic                  i_take
);

    dtv_pkg::t_entry r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [dtv_pkg::LenW-1:0] r_pos, r_len, n_pos, n_len;
    logic [3:0] r_pad, n_pad;

    dtv_pkg::t_entry e;
    logic wr, acc;
    logic [dtv_pkg::LenW-1:0] pos, len, pend;
    logic [3:0] pad;
    logic go;

    assign o_full  = (r_cnt == 3'd4);
    assign acc     = i_push && !o_full;
    assign o_valid = (r_cnt != 3'd0);
    assign o_entry = r_mem[r_rp];

    always_comb begin
        n_pos = r_pos;
        n_len = r_len;
        n_pad = r_pad;
        e     = '0;
        wr    = 1'b0;
        go    = 1'b0;
        pos   = r_pos;
        len   = r_len;
        pad   = r_pad;
        pend  = '0;
        e.data = i_data_byte;
        if (i_is_first) begin
            len     = i_total_bytes;
            pos     = '0;
            e.first = 1'b1;
            n_len   = i_total_bytes;
            n_pos   = '0;
            n_pad   = '0;
            if (i_total_bytes == '0) begin
                e.final_b = 1'b1;
                wr        = 1'b1;
            end else begin
                go = 1'b1;
            end
        end else if (r_pos < r_len) begin
            go = 1'b1;
        end
        if (go) begin
            wr    = 1'b1;
            e.pos = pos;
            e.len = len;
            if (pos == '0) begin
                e.pos0   = 1'b1;
                e.padbad = (i_data_byte >= dtv_pkg::BlockBytes[7:0]) ||
                           ({1'b0, len} <= ({17'd0, i_data_byte} + 25'd1));
                n_pad    = e.padbad ? 4'd0 : i_data_byte[3:0];
            end else begin
                pend      = len - {20'd0, pad};
                e.payload = (pos < pend);
                e.lastpay = (pos == pend - 24'd1);
            end
            e.final_b = ({1'b0, pos} + 25'd1 == {1'b0, len});
            n_pos     = pos + 24'd1;
        end
        if (!acc) begin
            n_pos = r_pos;
            n_len = r_len;
            n_pad = r_pad;
            wr    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_pos <= '0;
            r_len <= '0;
            r_pad <= '0;
        end else begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_pad <= n_pad;
            if (wr) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_take && o_valid) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, wr} - {2'd0, (i_take && o_valid)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= e;
        end
    end

endmodule

// ----- src/dtv_back.sv -----
// ----------------------------------------------------------------------------
// dtv_back
// Applies queued bytes to the table parse state and forms the final status.
// ----------------------------------------------------------------------------
module dtv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  dtv_pkg::t_entry  i_entry,
    output logic             o_take,
    input  logic             i_room,
    input  dtv_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output dtv_pkg::t_result o_res
);

    localparam int LW = dtv_pkg::LenW;
    localparam int CW = dtv_pkg::ColW;

    logic [LW-1:0] r_len, n_len, r_lstart, n_lstart, r_rows, n_rows, r_mrow, n_mrow;
    logic [LW-1:0] r_onul, n_onul, r_oline, n_oline, r_opad, n_opad, r_orow, n_orow;
    logic [3:0]    r_pad, n_pad;
    logic          r_cr, n_cr, r_lne, n_lne, r_hdr, n_hdr, r_fe, n_fe;
    logic [CW-1:0] r_hcol, n_hcol, r_tally, n_tally;
    logic          r_fnul, n_fnul, r_fline, n_fline, r_fpl, n_fpl, r_fpnz, n_fpnz;
    logic          r_fen, n_fen, r_fmm, n_fmm;
    logic          r_fin;

    dtv_pkg::t_entry e;
    logic [7:0] b;
    logic       skip;

    assign o_take = i_valid && i_room;
    assign e      = i_entry;
    assign b      = i_entry.data;

    always_comb begin
        n_len = r_len;  n_lstart = r_lstart; n_rows = r_rows; n_mrow = r_mrow;
        n_onul = r_onul; n_oline = r_oline; n_opad = r_opad; n_orow = r_orow;
        n_pad = r_pad; n_cr = r_cr; n_lne = r_lne; n_hdr = r_hdr; n_fe = r_fe;
        n_hcol = r_hcol; n_tally = r_tally;
        n_fnul = r_fnul; n_fline = r_fline; n_fpl = r_fpl; n_fpnz = r_fpnz;
        n_fen = r_fen; n_fmm = r_fmm;
        skip = 1'b0;
        if (o_take) begin
            if (e.first) begin
                n_len = e.len; n_lstart = '0; n_rows = '0; n_mrow = '0;
                n_onul = '0; n_oline = '0; n_opad = '0; n_orow = '0;
                n_pad = '0; n_cr = 1'b0; n_lne = 1'b0; n_hdr = 1'b0; n_fe = 1'b1;
                n_hcol = '0; n_tally = '0;
                n_fnul = 1'b0; n_fline = 1'b0; n_fpl = 1'b0; n_fpnz = 1'b0;
                n_fen = 1'b0; n_fmm = 1'b0;
            end
            if (e.pos0 && !(e.first && e.final_b && e.len == '0)) begin
                if (e.padbad) begin
                    n_fpl = 1'b1;
                    n_pad = '0;
                end else begin
                    n_pad = b[3:0];
                end
            end else if (e.payload) begin
                if (b == dtv_pkg::ChNul && !n_fnul) begin
                    n_fnul = 1'b1;
                    n_onul = e.pos;
                end
                if (n_cr) begin
                    n_cr = 1'b0;
                    if (b == dtv_pkg::ChLf) begin
                        skip = 1'b1;
                        if (n_lne) begin
                            if (!n_hdr) begin
                                if (n_fe) n_fen = 1'b1;
                                n_hcol = n_tally;
                                n_hdr  = 1'b1;
                            end else begin
                                if (n_tally != n_hcol && !n_fmm) begin
                                    n_fmm  = 1'b1;
                                    n_orow = n_lstart;
                                    n_mrow = n_rows;
                                end
                                if (n_rows < dtv_pkg::LenMax) n_rows = n_rows + 24'd1;
                            end
                            n_lne = 1'b0;
                        end
                    end else if (!n_fline) begin
                        n_fline = 1'b1;
                        n_oline = e.pos - 24'd1;
                    end
                end
                if (!skip) begin
                    if (b == dtv_pkg::ChCr) begin
                        n_cr = 1'b1;
                    end else if (b == dtv_pkg::ChLf) begin
                        if (!n_fline) begin
                            n_fline = 1'b1;
                            n_oline = e.pos;
                        end
                    end else begin
                        if (!n_lne) begin
                            n_lne    = 1'b1;
                            n_lstart = e.pos;
                            n_tally  = 11'd1;
                            n_fe     = 1'b1;
                        end
                        if (b == i_cfg.separator) begin
                            if (!n_hdr && n_fe) n_fen = 1'b1;
                            if (n_tally < dtv_pkg::TallyMax) n_tally = n_tally + 11'd1;
                            n_fe = 1'b1;
                        end else begin
                            n_fe = 1'b0;
                        end
                    end
                end
                if (e.lastpay) begin
                    if (n_cr) begin
                        if (!n_fline) begin
                            n_fline = 1'b1;
                            n_oline = e.pos;
                        end
                        n_cr = 1'b0;
                    end
                    if (n_lne) begin
                        if (!n_hdr) begin
                            if (n_fe) n_fen = 1'b1;
                            n_hcol = n_tally;
                            n_hdr  = 1'b1;
                        end else begin
                            if (n_tally != n_hcol && !n_fmm) begin
                                n_fmm  = 1'b1;
                                n_orow = n_lstart;
                                n_mrow = n_rows;
                            end
                            if (n_rows < dtv_pkg::LenMax) n_rows = n_rows + 24'd1;
                        end
                        n_lne = 1'b0;
                    end
                end
            end else if (!e.pos0 && b != dtv_pkg::ChNul && !n_fpnz) begin
                n_fpnz = 1'b1;
                n_opad = e.pos;
            end
        end
    end

    logic [CW-1:0] colmax;
    logic [LW-1:0] payload, over;

    assign colmax  = (i_cfg.max_columns < dtv_pkg::ColBound) ? i_cfg.max_columns
                                                               : dtv_pkg::ColBound;
    assign payload = r_len - {20'd0, r_pad} - 24'd1;
    assign over    = r_len - i_cfg.max_payload;

    always_comb begin
        o_res = '0;
        priority if (i_cfg.separator == dtv_pkg::ChNul || i_cfg.separator == dtv_pkg::ChCr
                     || i_cfg.separator == dtv_pkg::ChLf) begin
            o_res.status = dtv_pkg::ST_SEP;
        end else if (r_len == '0) begin
            o_res.status = dtv_pkg::ST_EMPTY;
        end else if (r_len[dtv_pkg::BlockBits-1:0] != '0) begin
            o_res.status       = dtv_pkg::ST_SIZE;
            o_res.error_offset = r_len;
        end else if (r_len > i_cfg.max_payload && over > dtv_pkg::BlockBytes) begin
            o_res.status       = dtv_pkg::ST_LIMIT;
            o_res.error_offset = r_len;
        end else if (r_fpl) begin
            o_res.status = dtv_pkg::ST_PADLEN;
        end else if (r_fpnz) begin
            o_res.status       = dtv_pkg::ST_PADNZ;
            o_res.error_offset = r_opad;
        end else if (payload > i_cfg.max_payload) begin
            o_res.status       = dtv_pkg::ST_LIMIT;
            o_res.error_offset = payload;
        end else if (r_fnul) begin
            o_res.status       = dtv_pkg::ST_NUL;
            o_res.error_offset = r_onul;
        end else if (r_fline) begin
            o_res.status       = dtv_pkg::ST_LINEEND;
            o_res.error_offset = r_oline;
        end else if (!r_hdr) begin
            o_res.status       = dtv_pkg::ST_NOHDR;
            o_res.error_offset = 24'd1;
        end else if (r_hcol > colmax) begin
            o_res.status       = dtv_pkg::ST_COLS;
            o_res.error_offset = 24'd1;
        end else if (r_fen) begin
            o_res.status       = dtv_pkg::ST_EMPTYNAME;
            o_res.error_offset = 24'd1;
        end else if (r_rows > i_cfg.max_rows) begin
            o_res.status       = dtv_pkg::ST_ROWS;
            o_res.error_offset = 24'd1;
        end else if (r_fmm) begin
            o_res.status       = dtv_pkg::ST_MISMATCH;
            o_res.error_offset = r_orow;
            o_res.row_idx      = r_mrow;
        end else begin
            o_res.status       = dtv_pkg::ST_OK;
            o_res.column_count = r_hcol;
            o_res.row_count    = r_rows;
            o_res.pad_bytes    = r_pad;
        end
    end

    assign o_res_valid = r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_lstart <= '0; r_rows <= '0; r_mrow <= '0;
            r_onul <= '0; r_oline <= '0; r_opad <= '0; r_orow <= '0;
            r_pad <= '0; r_cr <= 1'b0; r_lne <= 1'b0; r_hdr <= 1'b0; r_fe <= 1'b1;
            r_hcol <= '0; r_tally <= '0;
            r_fnul <= 1'b0; r_fline <= 1'b0; r_fpl <= 1'b0; r_fpnz <= 1'b0;
            r_fen <= 1'b0; r_fmm <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_len <= n_len; r_lstart <= n_lstart; r_rows <= n_rows; r_mrow <= n_mrow;
            r_onul <= n_onul; r_oline <= n_oline; r_opad <= n_opad; r_orow <= n_orow;
            r_pad <= n_pad; r_cr <= n_cr; r_lne <= n_lne; r_hdr <= n_hdr; r_fe <= n_fe;
            r_hcol <= n_hcol; r_tally <= n_tally;
            r_fnul <= n_fnul; r_fline <= n_fline; r_fpl <= n_fpl; r_fpnz <= n_fpnz;
            r_fen <= n_fen; r_fmm <= n_fmm;
            r_fin <= o_take && e.final_b;
        end
    end

endmodule

// ----- src/dtv_outq.sv -----
// ----------------------------------------------------------------------------
// dtv_outq
// Four-entry result queue; reports room while a pending result still fits.
// ----------------------------------------------------------------------------
module dtv_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  dtv_pkg::t_result i_data,
    output logic             o_room,
    output logic             o_empty,
    input  logic             i_pop,
    output dtv_pkg::t_result o_data
);

    dtv_pkg::t_result r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       rd;

    assign o_empty = (r_cnt == 3'd0);
    assign o_room  = (r_cnt < 3'd3);
    assign o_data  = r_mem[r_rp];
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 2'd1;
            if (rd)   r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_wr} - {2'd0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- src/delimited_table_stream_validator.sv -----
// ----------------------------------------------------------------------------
// delimited_table_stream_validator
// Validates a plaintext byte stream as a delimited table, one status per stream.
// ----------------------------------------------------------------------------
// channel   | handshake           | payload
// input     | push / full         | i_data_byte, i_is_first, i_total_bytes
// result    | empty / pop         | o_status .. o_pad_bytes
// config    | APB psel/penable    | paddr[3:2] selects register, pwdata
//
// One byte per cycle sustained while full is low; a byte's request passes a
// 4-entry queue and the back end's registered state update. Reset is
// synchronous; a stalled result side fills the result queue, then the byte
// queue, then raises full.
module delimited_table_stream_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_first,
    input  logic [23:0] i_total_bytes,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_status,
    output logic [23:0] o_error_offset,
    output logic [23:0] o_row_idx,
    output logic [10:0] o_column_count,
    output logic [23:0] o_row_count,
    output logic [3:0]  o_pad_bytes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dtv_pkg::t_cfg    r_cfg;
    dtv_pkg::t_entry  entry;
    dtv_pkg::t_result res, qres;
    logic             fvalid, take, room, res_valid;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator   <= 8'd44;
            r_cfg.max_payload <= 24'd1048576;
            r_cfg.max_columns <= 11'd64;
            r_cfg.max_rows    <= 24'd65535;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                dtv_pkg::REG_SEP:     r_cfg.separator   <= pwdata[7:0];
                dtv_pkg::REG_MAXPAY:  r_cfg.max_payload <= pwdata[23:0];
                dtv_pkg::REG_MAXCOL:  r_cfg.max_columns <= pwdata[10:0];
                dtv_pkg::REG_MAXROWS: r_cfg.max_rows    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            dtv_pkg::REG_SEP:     prdata = {24'd0, r_cfg.separator};
            dtv_pkg::REG_MAXPAY:  prdata = {8'd0, r_cfg.max_payload};
            dtv_pkg::REG_MAXCOL:  prdata = {21'd0, r_cfg.max_columns};
            dtv_pkg::REG_MAXROWS: prdata = {8'd0, r_cfg.max_rows};
            default:              prdata = '0;
        endcase
    end

    dtv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_data_byte   (i_data_byte),
        .i_is_first    (i_is_first),
        .i_total_bytes (i_total_bytes),
        .o_valid       (fvalid),
        .o_entry       (entry),
        .i_take        (take)
    );

    dtv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (fvalid),
        .i_entry     (entry),
        .o_take      (take),
        .i_room      (room),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dtv_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_data  (res),
        .o_room  (room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (qres)
    );

    assign o_status       = qres.status;
    assign o_error_offset = qres.error_offset;
    assign o_row_idx      = qres.row_idx;
    assign o_column_count = qres.column_count;
    assign o_row_count    = qres.row_count;
    assign o_pad_bytes    = qres.pad_bytes;

endmodule
